[hw/rtl/ssc_pkg.sv]
package ssc_pkg;

   localparam int PATH_DEPTH = 1024;
   localparam int ADDR_W = $clog2(PATH_DEPTH);
   localparam int CNT_W = 11;
   localparam int CORDIC_STEPS = 16;
   localparam int DRAIN_CYCLES = 4;

   localparam logic signed [23:0] PI_Q20 = 24'sd3294199;
   localparam logic signed [23:0] HALF_PI_Q20 = 24'sd1647099;
   localparam logic signed [33:0] CORDIC_K_Q30 = 34'sd652032874;
   localparam logic signed [16:0] PI_Q13 = 17'sd25736;
   localparam logic signed [16:0] TWO_PI_Q13 = 17'sd51472;

   localparam logic [1:0] CSR_STEER_GAIN = 2'd0;
   localparam logic [1:0] CSR_WHEELBASE = 2'd1;
   localparam logic [1:0] CSR_POINT_COUNT = 2'd2;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_CONTROL = 1'b1;

   typedef struct packed {
      logic               operation;
      logic [9:0]         point_index;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [15:0] point_heading;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [15:0] pos_heading;
      logic signed [15:0] speed;
   } req_type;

   typedef struct packed {
      logic signed [16:0] steer_angle;
      logic [9:0]         target_index;
      logic signed [31:0] cross_track_error;
      logic               at_final_point;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SC, ST_SC_FIN, ST_FRONT, ST_SCAN, ST_DRAIN,
      ST_MUL0, ST_MUL1, ST_MUL2, ST_MUL3, ST_ERR, ST_HEAD,
      ST_AT_INIT, ST_AT, ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      DP_NOP, DP_ACCEPT, DP_SC_ITER, DP_SC_FIN, DP_FRONT, DP_SCAN,
      DP_MUL_XS_LO, DP_MUL_XS_HI, DP_MUL_YC_LO, DP_MUL_YC_HI, DP_ERR,
      DP_HEAD, DP_AT_INIT, DP_AT_ITER, DP_DONE
   } dp_op_type;

   typedef struct packed {
      dp_op_type         op;
      logic [3:0]        iter;
      logic [ADDR_W-1:0] addr;
      logic              first;
      logic [ADDR_W-1:0] end_addr;
   } dp_cmd_type;

   function automatic logic signed [23:0] atan_q20(input logic [3:0] i);
      logic signed [23:0] r;
      case (i)
         4'd0: r = 24'sd823550;
         4'd1: r = 24'sd486170;
         4'd2: r = 24'sd256879;
         4'd3: r = 24'sd130396;
         4'd4: r = 24'sd65451;
         4'd5: r = 24'sd32757;
         4'd6: r = 24'sd16383;
         4'd7: r = 24'sd8192;
         4'd8: r = 24'sd4096;
         4'd9: r = 24'sd2048;
         4'd10: r = 24'sd1024;
         4'd11: r = 24'sd512;
         4'd12: r = 24'sd256;
         4'd13: r = 24'sd128;
         4'd14: r = 24'sd64;
         4'd15: r = 24'sd32;
         default: r = 24'sd0;
      endcase
      return r;
   endfunction

endpackage

[hw/rtl/ssc_ctrl.sv]
module ssc_ctrl import ssc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_op,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic [CNT_W-1:0] point_count,
   output dp_cmd_type       cmd
);

   state_type state_ff, state_in;
   logic [3:0] iter_ff, iter_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] n_eff;
   logic [CNT_W-1:0] last_pt;
   logic out_free;

   always_comb begin
      if (point_count == '0) begin
         n_eff = CNT_W'(1);
      end else if (point_count > CNT_W'(PATH_DEPTH)) begin
         n_eff = CNT_W'(PATH_DEPTH);
      end else begin
         n_eff = point_count;
      end
   end

   assign last_pt = n_eff - CNT_W'(1);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         iter_ff <= '0;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         iter_ff <= iter_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      iter_in = iter_ff;
      cnt_in = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op = DP_NOP;
      cmd.iter = iter_ff;
      cmd.addr = cnt_ff[ADDR_W-1:0];
      cmd.first = (cnt_ff == '0);
      cmd.end_addr = last_pt[ADDR_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op = DP_ACCEPT;
               // a load item is done in the accept cycle
               if (req_op == OP_CONTROL) begin
                  iter_in = '0;
                  state_in = ST_SC;
               end
            end
         end
         ST_SC: begin
            cmd.op = DP_SC_ITER;
            iter_in = iter_ff + 4'd1;
            if (iter_ff == 4'(CORDIC_STEPS - 1)) state_in = ST_SC_FIN;
         end
         ST_SC_FIN: begin
            cmd.op = DP_SC_FIN;
            state_in = ST_FRONT;
         end
         ST_FRONT: begin
            cmd.op = DP_FRONT;
            cnt_in = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.op = DP_SCAN;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == last_pt) begin
               cnt_in = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DRAIN_CYCLES - 1)) state_in = ST_MUL0;
         end
         ST_MUL0: begin
            cmd.op = DP_MUL_XS_LO;
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            cmd.op = DP_MUL_XS_HI;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.op = DP_MUL_YC_LO;
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            cmd.op = DP_MUL_YC_HI;
            state_in = ST_ERR;
         end
         ST_ERR: begin
            cmd.op = DP_ERR;
            state_in = ST_HEAD;
         end
         ST_HEAD: begin
            cmd.op = DP_HEAD;
            state_in = ST_AT_INIT;
         end
         ST_AT_INIT: begin
            cmd.op = DP_AT_INIT;
            iter_in = '0;
            state_in = ST_AT;
         end
         ST_AT: begin
            cmd.op = DP_AT_ITER;
            iter_in = iter_ff + 4'd1;
            if (iter_ff == 4'(CORDIC_STEPS - 1)) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.op = DP_DONE;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_done_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free) |=> rsp_valid_ff)
      else $error("result not presented after done");
   a_scan_to_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && cnt_ff == last_pt) |=> state_ff == ST_DRAIN)
      else $error("scan did not end at last point");
   a_head_before_atan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_AT_INIT) |-> $past(state_ff) == ST_HEAD)
      else $error("atan started without heading read");
`endif

endmodule

[hw/rtl/ssc_dp.sv]
module ssc_dp import ssc_pkg::*; (
   input  logic        clock,
   input  dp_cmd_type  cmd,
   input  req_type     req_data,
   input  logic [15:0] steer_gain,
   input  logic [15:0] wheelbase,
   input  logic        reset,
   output rsp_type     rsp_data
);

   logic signed [31:0] mem_x [PATH_DEPTH];
   logic signed [31:0] mem_y [PATH_DEPTH];
   logic signed [15:0] mem_h [PATH_DEPTH];
   logic signed [31:0] rd_x_ff, rd_y_ff;
   logic signed [15:0] rd_h_ff;
   logic [ADDR_W-1:0] rd_addr;

   logic signed [31:0] px_ff, py_ff;
   logic signed [15:0] yaw_ff, speed_ff;
   logic signed [33:0] cx_ff, cy_ff, s_ff, c_ff;
   logic signed [23:0] cz_ff;
   logic neg_ff;
   logic signed [34:0] fx_ff, fy_ff;

   // scan pipeline
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic [ADDR_W-1:0] i1_ff, i2_ff, i3_ff, i4_ff;
   logic signed [34:0] dx2_ff, dy2_ff, dx3_ff, dy3_ff, dx4_ff, dy4_ff;
   logic [34:0] mx2_ff, my2_ff;
   logic [35:0] xhh_ff, yhh_ff;
   logic [34:0] xhl_ff, yhl_ff;
   logic [33:0] xll_ff, yll_ff;
   logic [70:0] d4_ff, best_d_ff;
   logic found_ff;
   logic [ADDR_W-1:0] best_i_ff;
   logic signed [34:0] bdx_ff, bdy_ff;

   logic signed [69:0] acc1_ff, acc2_ff;
   logic signed [31:0] err_ff;
   logic [ADDR_W-1:0] cur_ff, last_ff;

   logic signed [51:0] ax_ff, ay_ff;
   logic signed [23:0] az_ff;
   logic zero_ff;
   logic signed [16:0] te_ff;
   rsp_type rsp_ff;

   assign rsp_data = rsp_ff;
   assign rd_addr = (cmd.op == DP_HEAD) ? cur_ff : cmd.addr;

   always_ff @(posedge clock) begin
      if (cmd.op == DP_ACCEPT && req_data.operation == OP_LOAD) begin
         mem_x[req_data.point_index] <= req_data.point_x;
         mem_y[req_data.point_index] <= req_data.point_y;
         mem_h[req_data.point_index] <= req_data.point_heading;
      end
      rd_x_ff <= mem_x[rd_addr];
      rd_y_ff <= mem_y[rd_addr];
      rd_h_ff <= mem_h[rd_addr];
   end

   // scan stages: distance squares split into 18- and 17-bit partial products
   always_ff @(posedge clock) begin
      logic signed [34:0] dx, dy;
      dx = fx_ff - 35'(rd_x_ff);
      dy = fy_ff - 35'(rd_y_ff);
      v1_ff <= (cmd.op == DP_SCAN);
      i1_ff <= cmd.addr;
      v2_ff <= v1_ff;
      i2_ff <= i1_ff;
      dx2_ff <= dx;
      dy2_ff <= dy;
      mx2_ff <= dx[34] ? 35'(-dx) : 35'(dx);
      my2_ff <= dy[34] ? 35'(-dy) : 35'(dy);
      v3_ff <= v2_ff;
      i3_ff <= i2_ff;
      dx3_ff <= dx2_ff;
      dy3_ff <= dy2_ff;
      xhh_ff <= mx2_ff[34:17] * mx2_ff[34:17];
      xhl_ff <= mx2_ff[34:17] * mx2_ff[16:0];
      xll_ff <= mx2_ff[16:0] * mx2_ff[16:0];
      yhh_ff <= my2_ff[34:17] * my2_ff[34:17];
      yhl_ff <= my2_ff[34:17] * my2_ff[16:0];
      yll_ff <= my2_ff[16:0] * my2_ff[16:0];
      v4_ff <= v3_ff;
      i4_ff <= i3_ff;
      dx4_ff <= dx3_ff;
      dy4_ff <= dy3_ff;
      d4_ff <= ({35'd0, xhh_ff} << 34) + ({36'd0, xhl_ff} << 18) + {37'd0, xll_ff}
             + ({35'd0, yhh_ff} << 34) + ({36'd0, yhl_ff} << 18) + {37'd0, yll_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         last_ff <= '0;
      end else begin
         if (cmd.op == DP_SCAN && cmd.first) begin
            found_ff <= 1'b0;
         end else if (v4_ff && (!found_ff || d4_ff <= best_d_ff)) begin
            found_ff <= 1'b1;
         end
         if (cmd.op == DP_ERR) last_ff <= (last_ff >= best_i_ff) ? last_ff : best_i_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (v4_ff && (!found_ff || d4_ff <= best_d_ff)) begin
         best_d_ff <= d4_ff;
         best_i_ff <= i4_ff;
         bdx_ff <= dx4_ff;
         bdy_ff <= dy4_ff;
      end
   end

   // sequenced arithmetic: sin/cos cordic, products, atan2 cordic
   always_ff @(posedge clock) begin
      logic signed [23:0] z0;
      logic signed [50:0] pc, ps;
      logic signed [69:0] t1w, t2w;
      logic signed [40:0] diff;
      logic signed [48:0] gy;
      logic signed [51:0] x0, y0;
      logic signed [16:0] te;
      logic signed [23:0] td;
      logic signed [23:0] tdr;
      case (cmd.op)
         DP_ACCEPT: begin
            px_ff <= req_data.pos_x;
            py_ff <= req_data.pos_y;
            yaw_ff <= req_data.pos_heading;
            speed_ff <= req_data.speed;
            z0 = 24'(req_data.pos_heading) <<< 7;
            cx_ff <= CORDIC_K_Q30;
            cy_ff <= '0;
            if (z0 > HALF_PI_Q20) begin
               cz_ff <= z0 - PI_Q20;
               neg_ff <= 1'b1;
            end else if (z0 < -HALF_PI_Q20) begin
               cz_ff <= z0 + PI_Q20;
               neg_ff <= 1'b1;
            end else begin
               cz_ff <= z0;
               neg_ff <= 1'b0;
            end
         end
         DP_SC_ITER: begin
            if (cz_ff >= 0) begin
               cx_ff <= cx_ff - (cy_ff >>> cmd.iter);
               cy_ff <= cy_ff + (cx_ff >>> cmd.iter);
               cz_ff <= cz_ff - atan_q20(cmd.iter);
            end else begin
               cx_ff <= cx_ff + (cy_ff >>> cmd.iter);
               cy_ff <= cy_ff - (cx_ff >>> cmd.iter);
               cz_ff <= cz_ff + atan_q20(cmd.iter);
            end
         end
         DP_SC_FIN: begin
            c_ff <= neg_ff ? -cx_ff : cx_ff;
            s_ff <= neg_ff ? -cy_ff : cy_ff;
         end
         DP_FRONT: begin
            pc = $signed({1'b0, wheelbase}) * c_ff;
            ps = $signed({1'b0, wheelbase}) * s_ff;
            fx_ff <= 35'(px_ff) + 35'((pc + 51'sd2097152) >>> 22);
            fy_ff <= 35'(py_ff) + 35'((ps + 51'sd2097152) >>> 22);
         end
         DP_MUL_XS_LO: acc1_ff <= 70'(bdx_ff * $signed({1'b0, s_ff[16:0]}));
         DP_MUL_XS_HI: acc1_ff <= acc1_ff + (70'(bdx_ff * $signed(s_ff[33:17])) <<< 17);
         DP_MUL_YC_LO: acc2_ff <= 70'(bdy_ff * $signed({1'b0, c_ff[16:0]}));
         DP_MUL_YC_HI: acc2_ff <= acc2_ff + (70'(bdy_ff * $signed(c_ff[33:17])) <<< 17);
         DP_ERR: begin
            t1w = (acc1_ff + 70'sd536870912) >>> 30;
            t2w = (acc2_ff + 70'sd536870912) >>> 30;
            diff = 41'(t1w) - 41'(t2w);
            if (diff > 41'sd2147483647) err_ff <= 32'sh7fffffff;
            else if (diff < -41'sd2147483648) err_ff <= 32'sh80000000;
            else err_ff <= 32'(diff);
            cur_ff <= (last_ff >= best_i_ff) ? last_ff : best_i_ff;
         end
         DP_AT_INIT: begin
            gy = $signed({1'b0, steer_gain}) * err_ff;
            y0 = 52'(gy);
            x0 = 52'(speed_ff) <<< 20;
            zero_ff <= (x0 == 0) && (y0 == 0);
            if (x0 < 0) begin
               ax_ff <= -x0;
               ay_ff <= -y0;
               az_ff <= (y0 >= 0) ? PI_Q20 : -PI_Q20;
            end else begin
               ax_ff <= x0;
               ay_ff <= y0;
               az_ff <= '0;
            end
            te = 17'(rd_h_ff) - 17'(yaw_ff);
            if (te > PI_Q13) te_ff <= te - TWO_PI_Q13;
            else if (te < -PI_Q13) te_ff <= te + TWO_PI_Q13;
            else te_ff <= te;
         end
         DP_AT_ITER: begin
            if (ay_ff >= 0) begin
               ax_ff <= ax_ff + (ay_ff >>> cmd.iter);
               ay_ff <= ay_ff - (ax_ff >>> cmd.iter);
               az_ff <= az_ff + atan_q20(cmd.iter);
            end else begin
               ax_ff <= ax_ff - (ay_ff >>> cmd.iter);
               ay_ff <= ay_ff + (ax_ff >>> cmd.iter);
               az_ff <= az_ff - atan_q20(cmd.iter);
            end
         end
         DP_DONE: begin
            td = zero_ff ? 24'sd0 : az_ff;
            tdr = (td + 24'sd64) >>> 7;
            rsp_ff.steer_angle <= te_ff + 17'(tdr);
            rsp_ff.target_index <= cur_ff;
            rsp_ff.cross_track_error <= err_ff;
            rsp_ff.at_final_point <= (cur_ff == cmd.end_addr);
         end
         default: begin
         end
      endcase
   end

endmodule

[hw/rtl/stanley_steering_controller_unit.sv]
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_ready  | req_data (req_type)
// rsp     | out       | rsp_valid/rsp_ready  | rsp_data (rsp_type)
// csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// a load item is done in its accept cycle; a control item's run is set by n, point_count
// held to 1..1024, through the nearest point scan over the path memory read port
// (one point a cycle) and the two 16-step cordic loops
// reset is synchronous and active high; path memory is not cleared
// a finished result waits in the output register; load items are still taken meanwhile,
// and a following control item stalls in its last cycle until the register is free
module stanley_steering_controller_unit import ssc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic [15:0] steer_gain_ff;
   logic [15:0] wheelbase_ff;
   logic [CNT_W-1:0] point_count_ff;
   dp_cmd_type cmd;

   // config writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         steer_gain_ff <= 16'd2048;
         wheelbase_ff <= 16'd640;
         point_count_ff <= CNT_W'(1);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_STEER_GAIN: steer_gain_ff <= csr_data;
            CSR_WHEELBASE: wheelbase_ff <= csr_data;
            CSR_POINT_COUNT: point_count_ff <= csr_data[CNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // sequencer
   ssc_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_op(req_data.operation),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .point_count(point_count_ff),
      .cmd(cmd)
   );

   // path memory, scan pipeline and cordic datapath
   ssc_dp u_dp (
      .clock(clock),
      .cmd(cmd),
      .req_data(req_data),
      .steer_gain(steer_gain_ff),
      .wheelbase(wheelbase_ff),
      .reset(reset),
      .rsp_data(rsp_data)
   );

endmodule
